// ===== design/drs_pkg.sv =====
package drs_pkg;

  localparam int TRACKS      = 1024;
  localparam int QUEUE_DEPTH = 1024;
  localparam int WORD_W      = 16;
  localparam int WORDS       = TRACKS / WORD_W;
  localparam int TRK_W       = $clog2(TRACKS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int WADDR_W     = TRK_W - BIT_W;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = SLOT_W + 1;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ADD     = 2'd0;
  localparam mode_t MODE_SERVE   = 2'd1;
  localparam mode_t MODE_RESTART = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_ACCEPTED = 3'd0;
  localparam status_t ST_SERVED   = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_RANGE    = 3'd3;
  localparam status_t ST_DUP      = 3'd4;
  localparam status_t ST_FULL     = 3'd5;
  localparam status_t ST_RESTART  = 3'd6;

  typedef logic [1:0] policy_t;
  localparam policy_t POL_FCFS  = 2'd0;
  localparam policy_t POL_SSTF  = 2'd1;
  localparam policy_t POL_LOOK  = 2'd2;
  localparam policy_t POL_CLOOK = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POLICY      = 2'd0;
  localparam cfg_idx_t CFG_TRACK_COUNT = 2'd1;
  localparam cfg_idx_t CFG_START_HEAD  = 2'd2;

  typedef struct packed {
    mode_t             mode;
    logic [TRK_W-1:0]  track;
  } in_item_t;

  typedef struct packed {
    logic [TRK_W-1:0]  served_track;
    status_t           status;
  } out_item_t;

  function automatic logic [BIT_W-1:0] f_highest(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== design/disk_request_scheduler_core.sv =====
// disk request scheduler core
// input channel: in_data {mode, track} is taken on a clock edge with start high
// and busy low. mode add queues a track, serve picks and removes the next one by
// the configured policy, restart drops all pending requests and loads the head.
// result channel: one beat per item on out_data {served_track, status}, marked
// by out_valid for one cycle; the receiver cannot stall, so no beat is held.
// config port: cfg_we, cfg_index, cfg_data write policy, track_count and
// start_head; write only while busy is low and no result is outstanding.
// timing: out-of-range, empty serve and unused mode answer in the cycle after
// accept; an add reads, then evaluates. fcfs serves walk the arrival ring from
// the read pointer; other serves scan the pending bitmap through one shared
// 16-track word unit, one word per cycle, 64 words for 1024 tracks; shortest
// seek, a look reversal and a c-look wrap add a second pass. every serve then
// walks the read pointer over freed ring slots. a restart, and reset, run a
// clearing pass over ring and bitmap, busy high; config writes are still taken.
// after reset: policy fcfs, track_count 1024, start_head 0, head at track 0.
module disk_request_scheduler_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  drs_pkg::in_item_t  in_data,
  output logic               out_valid,
  output drs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  drs_pkg::cfg_idx_t  cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int TRK_W   = drs_pkg::TRK_W;
  localparam int BIT_W   = drs_pkg::BIT_W;
  localparam int WADDR_W = drs_pkg::WADDR_W;
  localparam int SLOT_W  = drs_pkg::SLOT_W;
  localparam int CNT_W   = drs_pkg::CNT_W;
  localparam int WORD_W  = drs_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_ADD_RD, S_ADD_EV, S_FC_RD, S_FC_EV, S_SCAN, S_PICK,
    S_RM_RD, S_RM_EV, S_UP_RD, S_UP_EV
  } state_t;

  // memories
  logic [WORD_W-1:0] bits_mem [drs_pkg::WORDS];
  logic [SLOT_W-1:0] slot_mem [drs_pkg::TRACKS];
  logic [TRK_W:0]    ring_mem [drs_pkg::QUEUE_DEPTH];

  logic [WORD_W-1:0] bits_rd_r;
  logic [SLOT_W-1:0] slot_rd_r;
  logic [TRK_W:0]    ring_rd_r;

  logic [WADDR_W-1:0] br_addr, bw_addr;
  logic               bw_en;
  logic [WORD_W-1:0]  bw_data;
  logic [TRK_W-1:0]   sr_addr;
  logic               sw_en;
  logic [SLOT_W-1:0]  rr_addr, rw_addr;
  logic               rw_en;
  logic [TRK_W:0]     rw_data;

  state_t state_r, state_nxt;
  drs_pkg::policy_t policy_r, policy_nxt;
  logic [10:0]        tcount_r, tcount_nxt;
  logic [TRK_W-1:0]   shead_r, shead_nxt;
  logic [SLOT_W-1:0]  rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TRK_W-1:0]   head_r, head_nxt;
  logic               sweep_up_r, sweep_up_nxt;
  logic [TRK_W-1:0]   trk_r, trk_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               clr_report_r, clr_report_nxt;
  logic               out_valid_r, out_valid_nxt;
  drs_pkg::out_item_t out_data_r, out_data_nxt;
  // scan unit
  logic               dir_up_r, dir_up_nxt;
  logic [TRK_W-1:0]   org_r, org_nxt;
  logic [WADDR_W-1:0] scan_w_r, scan_w_nxt, rd_w_r, rd_w_nxt;
  logic               issue_r, issue_nxt, rdv_r, rdv_nxt;
  logic               phase_r, phase_nxt;
  logic               dn_found_r, dn_found_nxt;
  logic [TRK_W-1:0]   dn_t_r, dn_t_nxt;
  logic               up_found_r, up_found_nxt;

  logic [WORD_W-1:0]  masked;
  logic               hit, at_term, scan_done;
  logic [TRK_W-1:0]   hit_trk;
  logic [TRK_W-1:0]   d_dn, d_up;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (bw_en) bits_mem[bw_addr] <= bw_data;
    if (sw_en) slot_mem[trk_r] <= wr_ptr_r;
    if (rw_en) ring_mem[rw_addr] <= rw_data;
    bits_rd_r <= bits_mem[br_addr];
    slot_rd_r <= slot_mem[sr_addr];
    ring_rd_r <= ring_mem[rr_addr];
  end

  // word evaluation of the scan unit
  always_comb begin
    masked = bits_rd_r;
    if (rd_w_r == org_r[TRK_W-1:BIT_W]) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (dir_up_r) begin
          if (BIT_W'(i) < org_r[BIT_W-1:0]) masked[i] = 1'b0;
        end else begin
          if (BIT_W'(i) > org_r[BIT_W-1:0]) masked[i] = 1'b0;
        end
      end
    end
    hit     = |masked;
    hit_trk = {rd_w_r, dir_up_r ? drs_pkg::f_lowest(masked) : drs_pkg::f_highest(masked)};
    at_term = dir_up_r ? (rd_w_r == WADDR_W'(drs_pkg::WORDS - 1)) : (rd_w_r == '0);
    scan_done = rdv_r && (hit || at_term);
    d_dn = head_r - dn_t_r;
    d_up = trk_r - head_r;
  end

  always_comb begin
    state_nxt      = state_r;
    policy_nxt     = policy_r;
    tcount_nxt     = tcount_r;
    shead_nxt      = shead_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    sweep_up_nxt   = sweep_up_r;
    trk_nxt        = trk_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    dir_up_nxt     = dir_up_r;
    org_nxt        = org_r;
    scan_w_nxt     = scan_w_r;
    rd_w_nxt       = scan_w_r;
    issue_nxt      = issue_r;
    rdv_nxt        = 1'b0;
    phase_nxt      = phase_r;
    dn_found_nxt   = dn_found_r;
    dn_t_nxt       = dn_t_r;
    up_found_nxt   = up_found_r;

    br_addr = trk_r[TRK_W-1:BIT_W];
    bw_addr = trk_r[TRK_W-1:BIT_W];
    bw_en   = 1'b0;
    bw_data = bits_rd_r;
    sr_addr = trk_r;
    sw_en   = 1'b0;
    rr_addr = rd_ptr_r;
    rw_addr = wr_ptr_r;
    rw_en   = 1'b0;
    rw_data = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        drs_pkg::CFG_POLICY:      policy_nxt = cfg_data[1:0];
        drs_pkg::CFG_TRACK_COUNT: tcount_nxt = cfg_data;
        drs_pkg::CFG_START_HEAD:  shead_nxt  = cfg_data[TRK_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          trk_nxt = in_data.track;
          out_data_nxt.served_track = '0;
          unique case (in_data.mode)
            drs_pkg::MODE_ADD: begin
              if (11'(in_data.track) >= tcount_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status = drs_pkg::ST_RANGE;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end
            drs_pkg::MODE_SERVE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt.status = drs_pkg::ST_EMPTY;
              end else if (policy_r == drs_pkg::POL_FCFS) begin
                state_nxt = S_FC_RD;
              end else begin
                state_nxt  = S_SCAN;
                phase_nxt  = 1'b0;
                org_nxt    = head_r;
                scan_w_nxt = head_r[TRK_W-1:BIT_W];
                issue_nxt  = 1'b1;
                dir_up_nxt = (policy_r == drs_pkg::POL_SSTF) ? 1'b0 :
                             (policy_r == drs_pkg::POL_LOOK) ? sweep_up_r : 1'b0;
              end
            end
            drs_pkg::MODE_RESTART: begin
              state_nxt      = S_CLR;
              clr_cnt_nxt    = '0;
              clr_report_nxt = 1'b1;
              rd_ptr_nxt     = '0;
              wr_ptr_nxt     = '0;
              count_nxt      = '0;
              sweep_up_nxt   = 1'b0;
              head_nxt       = shead_r;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt.status = drs_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      S_CLR: begin
        bw_en   = 1'b1;
        bw_addr = clr_cnt_r[WADDR_W-1:0];
        bw_data = '0;
        rw_en   = 1'b1;
        rw_addr = clr_cnt_r;
        rw_data = '0;
        clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);
        if (clr_cnt_r == SLOT_W'(drs_pkg::QUEUE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          if (clr_report_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.served_track = '0;
            out_data_nxt.status = drs_pkg::ST_RESTART;
          end
        end
      end
      S_ADD_RD: begin
        rr_addr   = wr_ptr_r;
        state_nxt = S_ADD_EV;
      end
      S_ADD_EV: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (bits_rd_r[trk_r[BIT_W-1:0]]) begin
          out_data_nxt.status = drs_pkg::ST_DUP;
        end else if (ring_rd_r[TRK_W]) begin
          out_data_nxt.status = drs_pkg::ST_FULL;
        end else begin
          out_data_nxt.status = drs_pkg::ST_ACCEPTED;
          bw_en   = 1'b1;
          bw_data = bits_rd_r | (WORD_W'(1) << trk_r[BIT_W-1:0]);
          sw_en   = 1'b1;
          rw_en   = 1'b1;
          rw_data = {1'b1, trk_r};
          wr_ptr_nxt = (wr_ptr_r == SLOT_W'(drs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                       wr_ptr_r + SLOT_W'(1);
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      S_FC_RD: begin
        state_nxt = S_FC_EV;
      end
      S_FC_EV: begin
        if (ring_rd_r[TRK_W]) begin
          trk_nxt   = ring_rd_r[TRK_W-1:0];
          state_nxt = S_RM_RD;
        end else begin
          rd_ptr_nxt = (rd_ptr_r == SLOT_W'(drs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                       rd_ptr_r + SLOT_W'(1);
          state_nxt  = S_FC_RD;
        end
      end
      S_SCAN: begin
        br_addr = scan_w_r;
        rdv_nxt = issue_r;
        if (issue_r) begin
          if (dir_up_r ? (scan_w_r == WADDR_W'(drs_pkg::WORDS - 1)) : (scan_w_r == '0))
            issue_nxt = 1'b0;
          else
            scan_w_nxt = dir_up_r ? scan_w_r + WADDR_W'(1) : scan_w_r - WADDR_W'(1);
        end
        if (scan_done) begin
          rdv_nxt = 1'b0;
          trk_nxt = hit_trk;
          if (!phase_r) begin
            dn_found_nxt = hit;
            dn_t_nxt     = hit_trk;
            if (policy_r == drs_pkg::POL_SSTF || !hit) begin
              // second pass: up for sstf, reversal for look, wrap for c-look
              phase_nxt  = 1'b1;
              issue_nxt  = 1'b1;
              org_nxt    = head_r;
              dir_up_nxt = 1'b1;
              if (policy_r == drs_pkg::POL_LOOK) begin
                sweep_up_nxt = !sweep_up_r;
                dir_up_nxt   = !sweep_up_r;
              end else if (policy_r == drs_pkg::POL_CLOOK) begin
                org_nxt    = TRK_W'(drs_pkg::TRACKS - 1);
                dir_up_nxt = 1'b0;
              end
              scan_w_nxt = (policy_r == drs_pkg::POL_CLOOK) ?
                           WADDR_W'(drs_pkg::WORDS - 1) : head_r[TRK_W-1:BIT_W];
            end else begin
              state_nxt = S_RM_RD;
            end
          end else begin
            up_found_nxt = hit;
            state_nxt = (policy_r == drs_pkg::POL_SSTF) ? S_PICK : S_RM_RD;
          end
        end
      end
      S_PICK: begin
        state_nxt = S_RM_RD;
        if (!up_found_r || (dn_found_r && d_dn <= d_up)) trk_nxt = dn_t_r;
      end
      S_RM_RD: begin
        state_nxt = S_RM_EV;
      end
      S_RM_EV: begin
        bw_en      = 1'b1;
        bw_data    = bits_rd_r & ~(WORD_W'(1) << trk_r[BIT_W-1:0]);
        rw_en      = 1'b1;
        rw_addr    = slot_rd_r;
        rw_data    = '0;
        count_nxt  = count_r - CNT_W'(1);
        head_nxt   = trk_r;
        state_nxt  = S_UP_RD;
      end
      S_UP_RD: begin
        if (rd_ptr_r == wr_ptr_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.served_track = trk_r;
          out_data_nxt.status = drs_pkg::ST_SERVED;
        end else begin
          state_nxt = S_UP_EV;
        end
      end
      S_UP_EV: begin
        if (ring_rd_r[TRK_W]) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.served_track = trk_r;
          out_data_nxt.status = drs_pkg::ST_SERVED;
        end else begin
          rd_ptr_nxt = (rd_ptr_r == SLOT_W'(drs_pkg::QUEUE_DEPTH - 1)) ? '0 :
                       rd_ptr_r + SLOT_W'(1);
          state_nxt  = S_UP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      policy_r     <= drs_pkg::POL_FCFS;
      tcount_r     <= 11'(drs_pkg::TRACKS);
      shead_r      <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      count_r      <= '0;
      head_r       <= '0;
      sweep_up_r   <= 1'b0;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      issue_r      <= 1'b0;
      rdv_r        <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      policy_r     <= policy_nxt;
      tcount_r     <= tcount_nxt;
      shead_r      <= shead_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      sweep_up_r   <= sweep_up_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_r      <= issue_nxt;
      rdv_r        <= rdv_nxt;
      phase_r      <= phase_nxt;
    end
    trk_r      <= trk_nxt;
    out_data_r <= out_data_nxt;
    dir_up_r   <= dir_up_nxt;
    org_r      <= org_nxt;
    scan_w_r   <= scan_w_nxt;
    rd_w_r     <= rd_w_nxt;
    dn_found_r <= dn_found_nxt;
    dn_t_r     <= dn_t_nxt;
    up_found_r <= up_found_nxt;
  end

endmodule

// ===== design/drs_checker.sv =====
module drs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input drs_pkg::out_item_t out_data
);

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  a_no_beat_while_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy)) |-> !out_valid)
    else $error("result beat at start of a multi-cycle item");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 3'd7))
    else $error("undefined status code");

  a_track_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != drs_pkg::ST_SERVED) |-> (out_data.served_track == '0))
    else $error("served_track set on a non-serve result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("no clearing pass after reset");

endmodule

bind disk_request_scheduler_core drs_checker u_drs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam drs_pkg::mode_t MODE_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  drs_pkg::in_item_t  in_data;
  logic      out_valid;
  drs_pkg::out_item_t out_data;
  logic      cfg_we;
  drs_pkg::cfg_idx_t  cfg_index;
  logic [10:0] cfg_data;

  disk_request_scheduler_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // scheduler state mirror
  logic [1:0]  sch_policy;
  logic [10:0] sch_tcount;
  logic [9:0]  sch_start_head;
  logic        trk_pending [drs_pkg::TRACKS];
  logic [9:0]  trk_slot [drs_pkg::TRACKS];
  logic        slot_used [drs_pkg::QUEUE_DEPTH];
  logic [9:0]  slot_trk [drs_pkg::QUEUE_DEPTH];
  logic [9:0]  rd_ptr, wr_ptr, head;
  logic [10:0] n_pending;
  logic        sweep_up;

  drs_pkg::in_item_t  request_q[$];
  drs_pkg::out_item_t expected_q[$];
  int        errors;
  int        idle_pct;
  int        status_seen[8];
  int        beats_in;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_queues();
    for (int i = 0; i < drs_pkg::TRACKS; i++) trk_pending[i] = 1'b0;
    for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
    rd_ptr = '0;
    wr_ptr = '0;
    n_pending = '0;
    sweep_up = 1'b0;
  endfunction

  // highest pending track at or below h, -1 if none
  function automatic int scan_down(int h);
    for (int i = h; i >= 0; i--) if (trk_pending[i]) return i;
    return -1;
  endfunction

  function automatic int scan_up(int h);
    for (int i = h; i < drs_pkg::TRACKS; i++) if (trk_pending[i]) return i;
    return -1;
  endfunction

  function automatic int choose_track();
    int t;
    int bestd;
    t = 0;
    case (sch_policy)
      drs_pkg::POL_FCFS: begin
        for (int n = 0; n < drs_pkg::QUEUE_DEPTH; n++) begin
          if (slot_used[rd_ptr]) break;
          rd_ptr = rd_ptr + 1'b1;
        end
        t = slot_trk[rd_ptr];
      end
      drs_pkg::POL_SSTF: begin
        bestd = 1 << 20;
        for (int i = 0; i < drs_pkg::TRACKS; i++) begin
          if (trk_pending[i] && ((i >= head ? i - head : head - i) < bestd)) begin
            bestd = i >= head ? i - head : head - i;
            t = i;
          end
        end
      end
      drs_pkg::POL_LOOK: begin
        t = sweep_up ? scan_up(head) : scan_down(head);
        if (t < 0) begin
          sweep_up = ~sweep_up;
          t = sweep_up ? scan_up(head) : scan_down(head);
        end
      end
      default: begin
        t = scan_down(head);
        if (t < 0) t = scan_down(drs_pkg::TRACKS - 1);
      end
    endcase
    return t;
  endfunction

  function automatic drs_pkg::out_item_t schedule_step(drs_pkg::in_item_t it);
    drs_pkg::out_item_t r;
    int t;
    r = '0;
    case (it.mode)
      drs_pkg::MODE_ADD: begin
        if ({1'b0, it.track} >= sch_tcount) r.status = drs_pkg::ST_RANGE;
        else if (trk_pending[it.track]) r.status = drs_pkg::ST_DUP;
        else if (slot_used[wr_ptr]) r.status = drs_pkg::ST_FULL;
        else begin
          slot_used[wr_ptr] = 1'b1;
          slot_trk[wr_ptr] = it.track;
          trk_pending[it.track] = 1'b1;
          trk_slot[it.track] = wr_ptr;
          wr_ptr = wr_ptr + 1'b1;
          n_pending = n_pending + 1'b1;
          r.status = drs_pkg::ST_ACCEPTED;
        end
      end
      drs_pkg::MODE_SERVE: begin
        if (n_pending == 0) r.status = drs_pkg::ST_EMPTY;
        else begin
          t = choose_track();
          slot_used[trk_slot[t]] = 1'b0;
          trk_pending[t] = 1'b0;
          n_pending = n_pending - 1'b1;
          head = 10'(t);
          while (rd_ptr != wr_ptr && !slot_used[rd_ptr]) rd_ptr = rd_ptr + 1'b1;
          r.served_track = 10'(t);
          r.status = drs_pkg::ST_SERVED;
        end
      end
      drs_pkg::MODE_RESTART: begin
        clear_queues();
        head = sch_start_head;
        r.status = drs_pkg::ST_RESTART;
      end
      default: r.status = drs_pkg::ST_EMPTY;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(schedule_step(in_data));
        beats_in++;
      end
      if (!start || !busy) begin
        if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_data <= request_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, drs_pkg::out_item_t got,
                                 drs_pkg::out_item_t want);
    errors++;
    $display("%0t: %s got track %0d status %0d, want track %0d status %0d", $realtime,
             what, got.served_track, got.status, want.served_track, want.status);
  endtask

  // monitor
  always @(posedge clk) begin
    drs_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      status_seen[out_data.status]++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.status !== want.status || out_data.served_track !== want.served_track)
          report_mismatch("mismatch", out_data, want);
      end
    end
  end

  task automatic push_req(drs_pkg::mode_t m, logic [9:0] t);
    drs_pkg::in_item_t it;
    it.mode = m;
    it.track = t;
    request_q.push_back(it);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (request_q.size() > 0 || start || expected_q.size() > 0);
  endtask

  task automatic write_reg(drs_pkg::cfg_idx_t idx, logic [10:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      drs_pkg::CFG_POLICY:      sch_policy = v[1:0];
      drs_pkg::CFG_TRACK_COUNT: sch_tcount = v;
      default:                  sch_start_head = v[9:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int lim;
    int r;
    lim = (sch_tcount == 0) ? 1 :
          (sch_tcount > drs_pkg::TRACKS ? drs_pkg::TRACKS : sch_tcount);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 52) push_req(drs_pkg::MODE_ADD, ($urandom_range(9) == 0) ? 10'($urandom)
                                                   : 10'($urandom_range(lim - 1)));
      else if (r < 95) push_req(drs_pkg::MODE_SERVE, 10'($urandom));
      else if (r < 97) push_req(drs_pkg::MODE_RESTART, 10'($urandom));
      else push_req(MODE_UNUSED, 10'($urandom));
    end
  endtask

  initial begin
    int perm[drs_pkg::TRACKS];
    int j, tmp;
    int idle_modes[4] = '{0, 83, 0, 33};
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = drs_pkg::CFG_POLICY;
    cfg_data = '0;
    errors = 0;
    beats_in = 0;
    idle_pct = 0;
    sch_policy = drs_pkg::POL_FCFS;
    sch_tcount = 11'd1024;
    sch_start_head = '0;
    head = '0;
    clear_queues();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty serve, extremes, duplicate, unused mode
    push_req(drs_pkg::MODE_SERVE, 10'h3ff);
    push_req(drs_pkg::MODE_ADD, 10'd0);
    push_req(drs_pkg::MODE_ADD, 10'h3ff);
    push_req(drs_pkg::MODE_ADD, 10'h3ff);
    push_req(MODE_UNUSED, 10'd0);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    drain();
    write_reg(drs_pkg::CFG_POLICY, 11'd1);
    write_reg(drs_pkg::CFG_TRACK_COUNT, 11'd1);
    write_reg(drs_pkg::CFG_START_HEAD, 11'h3ff);
    push_req(drs_pkg::MODE_RESTART, 10'd0);
    push_req(drs_pkg::MODE_ADD, 10'd1);
    push_req(drs_pkg::MODE_ADD, 10'd0);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    drain();
    write_reg(drs_pkg::CFG_TRACK_COUNT, 11'd0);
    push_req(drs_pkg::MODE_ADD, 10'd0);
    drain();
    // track_count set above the 1024 tracks on purpose
    write_reg(drs_pkg::CFG_TRACK_COUNT, 11'h7ff);
    write_reg(drs_pkg::CFG_POLICY, 11'd2);
    push_req(drs_pkg::MODE_ADD, 10'd5);
    push_req(drs_pkg::MODE_ADD, 10'd1000);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    push_req(drs_pkg::MODE_SERVE, 10'd0);
    drain();

    // ring wrap: fill nearly all tracks, free slots out of order, then add past the wrap
    write_reg(drs_pkg::CFG_POLICY, 11'd3);
    write_reg(drs_pkg::CFG_START_HEAD, 11'd0);
    write_reg(drs_pkg::CFG_TRACK_COUNT, 11'd1024);
    for (int i = 0; i < drs_pkg::TRACKS; i++) perm[i] = i;
    for (int i = drs_pkg::TRACKS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    push_req(drs_pkg::MODE_RESTART, 10'd0);
    for (int i = 0; i < drs_pkg::TRACKS - 1; i++) push_req(drs_pkg::MODE_ADD, 10'(perm[i]));
    repeat (4) push_req(drs_pkg::MODE_SERVE, 10'd0);
    push_req(drs_pkg::MODE_ADD, 10'(perm[drs_pkg::TRACKS - 1]));
    for (int i = 0; i < 6; i++) push_req(drs_pkg::MODE_ADD, 10'($urandom));
    drain();

    // random phases across register settings and idle patterns
    for (int ph = 0; ph < 16; ph++) begin
      idle_pct = idle_modes[ph % 4];
      write_reg(drs_pkg::CFG_POLICY, 11'(ph % 4));
      case (ph / 4)
        0: write_reg(drs_pkg::CFG_TRACK_COUNT, 11'd1024);
        1: write_reg(drs_pkg::CFG_TRACK_COUNT, 11'($urandom_range(2, 40)));
        2: write_reg(drs_pkg::CFG_TRACK_COUNT, 11'($urandom_range(1, 1024)));
        default: write_reg(drs_pkg::CFG_TRACK_COUNT,
                           ($urandom_range(1)) ? 11'h7ff : 11'd1);
      endcase
      write_reg(drs_pkg::CFG_START_HEAD, (ph % 3 == 0) ? 11'd0 : (ph % 3 == 1) ? 11'h3ff
                                                  : 11'($urandom_range(1023)));
      if (ph % 2 == 0) push_req(drs_pkg::MODE_RESTART, 10'($urandom));
      random_burst(26);
      // stretch with the sender held until everything is back
      drain();
      random_burst(26);
      drain();
    end

    repeat (1200) @(posedge clk);
    $display("%0d beats sent: %0d accepted, %0d served, %0d empty, %0d restarts", beats_in,
             status_seen[drs_pkg::ST_ACCEPTED], status_seen[drs_pkg::ST_SERVED],
             status_seen[drs_pkg::ST_EMPTY], status_seen[drs_pkg::ST_RESTART]);
    $display("rejects: %0d out of range, %0d duplicate, %0d queue full",
             status_seen[drs_pkg::ST_RANGE], status_seen[drs_pkg::ST_DUP],
             status_seen[drs_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
